>>> rtl/core/mlk_pkg.sv
// Shared types and constants for the Morse LED keyer.
// Holds the command format passed front to back, the timing register set
// and the letter table. No dependencies.
package mlk_pkg;

    // Kind of work a character turns into
    typedef enum logic [1:0] {
        KIND_LETTER = 2'd0,
        KIND_SPACE  = 2'd1,
        KIND_END    = 2'd2,
        KIND_BAD    = 2'd3
    } t_kind;

    // Classified command: symbol count and pattern (first symbol in the
    // highest used bit, 1 = dash)
    typedef struct packed {
        t_kind       kind;
        logic [2:0]  len;
        logic [3:0]  pat;
    } t_cmd;

    // Timing registers, seconds
    typedef struct packed {
        logic [3:0] symbol_on;
        logic [3:0] element_off;
        logic [3:0] letter_gap;
        logic [3:0] word_flash;
        logic [3:0] end_on;
        logic [3:0] end_off;
    } t_times;

    // Register indexes on the config port
    localparam logic [2:0] REG_SYMBOL_ON   = 3'd0;
    localparam logic [2:0] REG_ELEMENT_OFF = 3'd1;
    localparam logic [2:0] REG_LETTER_GAP  = 3'd2;
    localparam logic [2:0] REG_WORD_FLASH  = 3'd3;
    localparam logic [2:0] REG_END_ON      = 3'd4;
    localparam logic [2:0] REG_END_OFF     = 3'd5;

    // Reset values of the timing registers
    localparam t_times TIMES_RESET = '{
        symbol_on:   4'd1,
        element_off: 4'd1,
        letter_gap:  4'd2,
        word_flash:  4'd1,
        end_on:      4'd2,
        end_off:     4'd1
    };

    // Character codes
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // Morse table: high nibble symbol count, low nibble pattern
    function automatic logic [7:0] morse_code(input logic [4:0] idx);
        logic [7:0] code;
        case (idx)
            5'd0:    code = 8'h21;  // A
            5'd1:    code = 8'h48;
            5'd2:    code = 8'h4A;
            5'd3:    code = 8'h34;
            5'd4:    code = 8'h10;
            5'd5:    code = 8'h42;
            5'd6:    code = 8'h36;
            5'd7:    code = 8'h40;
            5'd8:    code = 8'h20;
            5'd9:    code = 8'h47;
            5'd10:   code = 8'h35;
            5'd11:   code = 8'h44;
            5'd12:   code = 8'h23;
            5'd13:   code = 8'h22;
            5'd14:   code = 8'h37;
            5'd15:   code = 8'h46;
            5'd16:   code = 8'h4D;
            5'd17:   code = 8'h32;
            5'd18:   code = 8'h30;
            5'd19:   code = 8'h11;
            5'd20:   code = 8'h31;
            5'd21:   code = 8'h41;
            5'd22:   code = 8'h33;
            5'd23:   code = 8'h49;
            5'd24:   code = 8'h4B;
            5'd25:   code = 8'h4C;  // Z
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/core/mlk_front.sv
// Front end of the keyer: classifies one character into a command.
// Depends on mlk_pkg for the command type and the Morse table.
module mlk_front (
    input  logic              i_mode,
    input  logic [7:0]        i_char_code,
    output mlk_pkg::t_cmd     o_cmd
);

    logic [7:0] w_upper;
    logic [7:0] w_offset;
    logic [7:0] w_code;
    logic       w_is_letter;

    // Fold lower case onto upper case
    always_comb begin
        if (i_char_code >= mlk_pkg::CHAR_LOWER_A && i_char_code <= mlk_pkg::CHAR_LOWER_Z) begin
            w_upper = i_char_code - mlk_pkg::CASE_OFFSET;
        end else begin
            w_upper = i_char_code;
        end
    end

    assign w_is_letter = (w_upper >= mlk_pkg::CHAR_UPPER_A) &&
                         (w_upper <= mlk_pkg::CHAR_UPPER_Z);
    assign w_offset    = w_upper - mlk_pkg::CHAR_UPPER_A;
    assign w_code      = mlk_pkg::morse_code(w_offset[4:0]);

    // Classification
    always_comb begin
        o_cmd.len = w_code[6:4];
        o_cmd.pat = w_code[3:0];
        if (i_mode) begin
            o_cmd.kind = mlk_pkg::KIND_END;
        end else if (i_char_code == mlk_pkg::CHAR_SPACE) begin
            o_cmd.kind = mlk_pkg::KIND_SPACE;
        end else if (w_is_letter) begin
            o_cmd.kind = mlk_pkg::KIND_LETTER;
        end else begin
            o_cmd.kind = mlk_pkg::KIND_BAD;
        end
    end

endmodule

>>> rtl/core/mlk_cmd_queue.sv
// Two-entry command queue between the keyer front and back ends.
// Depends on mlk_pkg for the command type.
module mlk_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mlk_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output mlk_pkg::t_cmd     o_cmd,
    output logic              o_full,
    output logic              o_empty
);

    mlk_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/mlk_back.sv
// Back end of the keyer: plays one command out as LED steps, one per cycle.
// Depends on mlk_pkg for the command and timing types.
module mlk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlk_pkg::t_times   i_times,
    input  mlk_pkg::t_cmd     i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    output logic              o_red_on,
    output logic              o_yellow_on,
    output logic              o_green_on,
    output logic [3:0]        o_hold_time,
    output logic              o_bad_char,
    output logic              o_last
);

    mlk_pkg::t_cmd r_cmd;
    logic          r_active;
    logic [3:0]    r_step;

    logic       w_last_step;
    logic [2:0] w_bit;
    logic       w_dash;
    logic       n_red;
    logic       n_yellow;
    logic       n_green;
    logic [3:0] n_hold;
    logic       n_bad;

    // Final step of the current command
    always_comb begin
        case (r_cmd.kind)
            mlk_pkg::KIND_LETTER: w_last_step = (r_step == {r_cmd.len, 1'b0});
            mlk_pkg::KIND_SPACE:  w_last_step = (r_step == 4'd1);
            mlk_pkg::KIND_END:    w_last_step = (r_step == 4'd1);
            default:              w_last_step = 1'b1;
        endcase
    end

    assign o_pop  = !i_empty && (!r_active || w_last_step);
    assign w_bit  = r_cmd.len - 3'd1 - r_step[3:1];
    assign w_dash = r_cmd.pat[w_bit[1:0]];

    // Step decode
    always_comb begin
        n_red    = 1'b0;
        n_yellow = 1'b0;
        n_green  = 1'b0;
        n_hold   = 4'd0;
        n_bad    = 1'b0;
        case (r_cmd.kind)
            mlk_pkg::KIND_LETTER: begin
                if (w_last_step) begin
                    n_hold = i_times.letter_gap;
                end else if (r_step[0]) begin
                    n_hold = i_times.element_off;
                end else begin
                    n_red    = !w_dash;
                    n_yellow = w_dash;
                    n_hold   = i_times.symbol_on;
                end
            end
            mlk_pkg::KIND_SPACE: begin
                n_green = (r_step == 4'd0);
                n_hold  = (r_step == 4'd0) ? i_times.word_flash : i_times.element_off;
            end
            mlk_pkg::KIND_END: begin
                n_green = (r_step == 4'd0);
                n_hold  = (r_step == 4'd0) ? i_times.end_on : i_times.end_off;
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_step   <= 4'd0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_step   <= 4'd0;
            end else if (r_active && w_last_step) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_step <= r_step + 4'd1;
            end
        end
    end

    // Command and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        o_red_on    <= n_red;
        o_yellow_on <= n_yellow;
        o_green_on  <= n_green;
        o_hold_time <= n_hold;
        o_bad_char  <= n_bad;
        o_last      <= w_last_step;
    end

    // At most one LED lit per step
    a_one_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_red_on, o_yellow_on, o_green_on}) <= 1)
        else $error("more than one LED lit");

    // A bad character is a single dark step of zero length
    a_bad_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_char) |-> (o_last && o_hold_time == 4'd0 &&
                                     !o_red_on && !o_yellow_on && !o_green_on))
        else $error("bad character step malformed");

    // A command mid-way always delivers a non-final step next
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !w_last_step) |=> (o_valid && !o_last))
        else $error("step sequence broken");

endmodule

>>> rtl/core/morse_led_keyer.sv
// Top level of the Morse LED keyer: config registers, front, queue, back.
// Depends on mlk_pkg, mlk_front, mlk_cmd_queue and mlk_back.
//
// Usage:
//   Input: drive i_mode and i_char_code and raise i_start; the character is
//   taken at a clock edge where i_start is high and o_busy is low.
//   Output: each LED step appears for one cycle with o_valid high; o_last
//   marks the final step of a character. The receiver cannot stall.
//   A letter gives 2*n+1 steps (n symbols, n up to 4), a space or end of
//   message gives 2, any other character one step flagged o_bad_char.
//   A character passes through the command queue and the back-end command
//   register before its steps are registered onto the outputs. The back
//   end emits one step per cycle, without a bubble between characters when
//   the next is queued; the two-entry queue accepts while the back plays.
//   o_busy is high only while the queue is full.
//   Config: i_cfg_we writes i_cfg_data to timing register i_cfg_index
//   (0 symbol on, 1 element off, 2 letter gap, 3 word flash, 4 end on,
//   5 end off); other indexes are ignored. Write only while idle.
//   Reset: synchronous active low; empties the queue, stops the sequencer
//   and restores the default times.
module morse_led_keyer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_mode,
    input  logic [7:0] i_char_code,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    output logic       o_valid,
    output logic       o_red_on,
    output logic       o_yellow_on,
    output logic       o_green_on,
    output logic [3:0] o_hold_time,
    output logic       o_bad_char,
    output logic       o_last
);

    mlk_pkg::t_times r_times;
    mlk_pkg::t_cmd   w_front_cmd;
    mlk_pkg::t_cmd   w_queue_cmd;
    logic            w_full;
    logic            w_empty;
    logic            w_push;
    logic            w_pop;

    assign o_busy = w_full;
    assign w_push = i_start && !w_full;

    // Timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_times <= mlk_pkg::TIMES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mlk_pkg::REG_SYMBOL_ON:   r_times.symbol_on   <= i_cfg_data;
                mlk_pkg::REG_ELEMENT_OFF: r_times.element_off <= i_cfg_data;
                mlk_pkg::REG_LETTER_GAP:  r_times.letter_gap  <= i_cfg_data;
                mlk_pkg::REG_WORD_FLASH:  r_times.word_flash  <= i_cfg_data;
                mlk_pkg::REG_END_ON:      r_times.end_on      <= i_cfg_data;
                mlk_pkg::REG_END_OFF:     r_times.end_off     <= i_cfg_data;
                default:                  r_times <= r_times;
            endcase
        end
    end

    mlk_front u_front (
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .o_cmd       (w_front_cmd)
    );

    mlk_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mlk_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_times     (r_times),
        .i_cmd       (w_queue_cmd),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_red_on    (o_red_on),
        .o_yellow_on (o_yellow_on),
        .o_green_on  (o_green_on),
        .o_hold_time (o_hold_time),
        .o_bad_char  (o_bad_char),
        .o_last      (o_last)
    );

endmodule
